/* hdl/tccw_pkg.sv */
// Shared types and constants of the text console character writer.
// Depends on nothing; imported by the top level.
package tccw_pkg;

   // Field widths of the request and response transactions.
   localparam int FUNC_W = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int IDX_W  = 11;
   localparam int POS_W  = 11;
   localparam int CELL_W = CHAR_W + ATTR_W;

   // Default screen geometry.
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // Control characters, blank cell and tab stop spacing.
   localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam int                TAB_STEP   = 8;

   // Operation codes of a request.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

endpackage

/* hdl/tccw_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/text_console_character_writer_unit.sv */
// Top level of the text console character writer: sequencer, cursor and screen store.
// Depends on tccw_pkg and tccw_ram.
//
//  Channel   | Ports                                              | Handshake
//  ----------+----------------------------------------------------+---------------------------
//  request   | req_func, req_char_code, req_color, req_cell_index | start high while busy low
//  response  | rsp_cursor_pos, rsp_read_char, rsp_read_color,     | rsp_valid high one cycle,
//            | rsp_scrolled                                       | always taken
//
// Every request transaction yields exactly one response transaction. A printed
// character, a carriage return, a line feed or a tab that does not scroll passes
// through the put state for the cursor update, and a read of a cell through the
// read data state for the memory read, before the registered response. An unused
// operation or a read beyond the screen is answered straight from the idle state.
// Clearing the screen and a scroll run the single address sweep that walks the
// store one cell per cycle through the one write port, then its tail. After reset
// the same sweep clears the store to blanks with attribute 0x07 and keeps busy
// high until its tail is done. The receiver cannot stall responses.
module text_console_character_writer_unit #(
   parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [tccw_pkg::FUNC_W-1:0] req_func,
   input  logic [tccw_pkg::CHAR_W-1:0] req_char_code,
   input  logic [tccw_pkg::ATTR_W-1:0] req_color,
   input  logic [tccw_pkg::IDX_W-1:0]  req_cell_index,
   output logic                        rsp_valid,
   output logic [tccw_pkg::POS_W-1:0]  rsp_cursor_pos,
   output logic [tccw_pkg::CHAR_W-1:0] rsp_read_char,
   output logic [tccw_pkg::ATTR_W-1:0] rsp_read_color,
   output logic                        rsp_scrolled
);

   import tccw_pkg::*;

   // Geometry derived widths. The column and row step values carry one spare bit
   // so that a step past the last column or row is visible before it wraps.
   localparam int CELLS    = COLUMNS * ROWS;
   localparam int COPY_END = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CW       = $clog2(COLUMNS);
   localparam int CW1      = CW + 1;
   localparam int RW       = $clog2(ROWS);
   localparam int RW1      = RW + 1;
   localparam int PW       = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

   // One-hot sequencer states. SWEEP walks every cell once, for the clearing
   // pass after reset, for a clear request and for a scroll; TAIL lets the last
   // write of the sweep land and issues the response, except after the reset pass.
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PUT   = 5'b00010,
      S_RDATA = 5'b00100,
      S_SWEEP = 5'b01000,
      S_TAIL  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic                copy_ff, copy_in;
   logic                init_ff, init_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic                pend_copy_ff, pend_copy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic                rsp_scrolled_ff, rsp_scrolled_in;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [CELL_W-1:0]   ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [CELL_W-1:0]   ram_rd_data;

   logic [ADDR_W-1:0]   cur_addr;
   logic [PW-1:0]       idx_ext;
   logic                idx_ok;
   logic                ptr_in_copy;
   logic [CW1-1:0]      col_step;
   logic [CW1-1:0]      col_plus_tab;
   logic [RW1-1:0]      row_step;
   logic                printable;

   // Linear cell number of the cursor; feeds the write address and the
   // cursor position of every response.
   assign cur_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);

   assign idx_ext     = PW'(req_cell_index);
   assign idx_ok      = idx_ext < PW'(CELLS);
   assign ptr_in_copy = copy_ff && (ptr_ff < ADDR_W'(COPY_END));

   assign col_plus_tab = (CW1'(col_ff) + CW1'(TAB_STEP)) & ~CW1'(TAB_STEP - 1);
   assign printable    = (char_ff != CH_LF) && (char_ff != CH_CR) && (char_ff != CH_TAB);

   // Cursor movement of a put character transaction.
   always_comb begin
      col_step = CW1'(col_ff);
      row_step = RW1'(row_ff);
      if (char_ff == CH_LF) begin
         col_step = '0;
         row_step = RW1'(row_ff) + RW1'(1);
      end else if (char_ff == CH_CR) begin
         col_step = '0;
      end else if (char_ff == CH_TAB) begin
         col_step = col_plus_tab;
      end else begin
         col_step = CW1'(col_ff) + CW1'(1);
      end
      if (col_step >= CW1'(COLUMNS)) begin
         col_step = '0;
         row_step = row_step + RW1'(1);
      end
   end

   // Memory ports. A put writes at the cursor; during a sweep each write lands in
   // the cycle after its read, so a scroll copies a cell one row down from the
   // cell written, which the sweep has not yet touched.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_addr;
      ram_wr_data = {attr_ff, char_ff};
      if (pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pend_addr_ff;
         ram_wr_data = pend_copy_ff ? ram_rd_data : {attr_ff, CH_SPACE};
      end else if (state_ff == S_PUT && printable) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      ram_rd_addr = '0;
      if (state_ff == S_IDLE && idx_ok) begin
         ram_rd_addr = ADDR_W'(idx_ext);
      end else if (state_ff == S_SWEEP && ptr_in_copy) begin
         ram_rd_addr = ADDR_W'(ptr_ff + ADDR_W'(COLUMNS));
      end
   end

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      char_in         = char_ff;
      attr_in         = attr_ff;
      ptr_in          = ptr_ff;
      copy_in         = copy_ff;
      init_in         = init_ff;
      pend_in         = 1'b0;
      pend_addr_in    = ptr_ff;
      pend_copy_in    = ptr_in_copy;
      rsp_valid_in    = 1'b0;
      rsp_char_in     = rsp_char_ff;
      rsp_color_in    = rsp_color_ff;
      rsp_scrolled_in = rsp_scrolled_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               char_in = req_char_code;
               attr_in = req_color;
               unique case (func_type'(req_func))
                  FUNC_PUT: begin
                     state_in = S_PUT;
                  end
                  FUNC_READ: begin
                     if (idx_ok) begin
                        state_in = S_RDATA;
                     end else begin
                        rsp_valid_in    = 1'b1;
                        rsp_char_in     = '0;
                        rsp_color_in    = '0;
                        rsp_scrolled_in = 1'b0;
                     end
                  end
                  FUNC_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     ptr_in   = '0;
                     copy_in  = 1'b0;
                     state_in = S_SWEEP;
                  end
                  FUNC_NONE: begin
                     rsp_valid_in    = 1'b1;
                     rsp_char_in     = '0;
                     rsp_color_in    = '0;
                     rsp_scrolled_in = 1'b0;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_PUT: begin
            rsp_char_in     = '0;
            rsp_color_in    = '0;
            if (row_step >= RW1'(ROWS)) begin
               // Off the bottom: cursor stays on the last row and the store
               // is shifted up one row by a sweep.
               col_in   = '0;
               row_in   = RW'(ROWS - 1);
               ptr_in   = '0;
               copy_in  = 1'b1;
               state_in = S_SWEEP;
            end else begin
               col_in          = CW'(col_step);
               row_in          = RW'(row_step);
               rsp_valid_in    = 1'b1;
               rsp_scrolled_in = 1'b0;
               state_in        = S_IDLE;
            end
         end
         S_RDATA: begin
            rsp_valid_in    = 1'b1;
            rsp_char_in     = ram_rd_data[CHAR_W-1:0];
            rsp_color_in    = ram_rd_data[CELL_W-1:CHAR_W];
            rsp_scrolled_in = 1'b0;
            state_in        = S_IDLE;
         end
         S_SWEEP: begin
            pend_in = 1'b1;
            ptr_in  = ptr_ff + ADDR_W'(1);
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_IDLE;
            if (init_ff) begin
               init_in = 1'b0;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_char_in     = '0;
               rsp_color_in    = '0;
               rsp_scrolled_in = copy_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_SWEEP;
         col_ff          <= '0;
         row_ff          <= '0;
         attr_ff         <= RESET_ATTR;
         ptr_ff          <= '0;
         copy_ff         <= 1'b0;
         init_ff         <= 1'b1;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         attr_ff         <= attr_in;
         ptr_ff          <= ptr_in;
         copy_ff         <= copy_in;
         init_ff         <= init_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff         <= char_in;
      pend_addr_ff    <= pend_addr_in;
      pend_copy_ff    <= pend_copy_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_color_ff    <= rsp_color_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The cursor moves no later than the response is registered, so during the response
   // cycle it already holds the position after the step.
   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = POS_W'(PW'(cur_addr));
   assign rsp_read_char  = rsp_char_ff;
   assign rsp_read_color = rsp_color_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

   // A response always falls in a cycle where the next request can be taken.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("response issued while busy");

   // Delayed sweep writes only occur inside the sweep and its tail.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SWEEP || state_ff == S_TAIL))
      else $error("sweep write outside the sweep");

   // The cursor reported with a response lies on the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CW1'(col_ff) < CW1'(COLUMNS) && RW1'(row_ff) < RW1'(ROWS)))
      else $error("cursor off screen");

   // A scroll leaves the cursor at the start of the last row.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (row_ff == RW'(ROWS - 1) && col_ff == '0))
      else $error("scroll left cursor misplaced");

   // The clearing pass after reset ends before any request is taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !init_ff)
      else $error("idle before the store was cleared");

endmodule
